// ===== rtl/sst_pkg.sv =====
// Shared types and constants for the stopwatch slot table.
// Used by the controller, the datapath and the top level.
package sst_pkg;

    localparam int NUM_SLOTS_DEF   = 16;
    localparam int NUM_SOURCES_DEF = 3;
    localparam int PERIOD_W        = 26;
    localparam int WRAP_W          = 32;
    localparam int SLOT_ID_W       = 5;
    localparam int USEC_W          = 20;
    localparam logic [PERIOD_W-1:0] USEC_PER_SEC = 26'd1000000;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_NOT_FND  = 2'd2;
    localparam logic [1:0] ST_BAD_SRC  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] tick_mask;
        logic [1:0] source;
        logic [4:0] slot_id;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot_out;
        logic [31:0] elapsed_sec;
        logic [19:0] elapsed_usec;
    } t_out_beat;

    typedef struct packed {
        logic load;      // capture input beat, look up slot
        logic exec;      // perform tick/start/stop, or begin read
        logic mul_go;    // register the product
        logic div_step;  // one half-step of the byte-wise divide
        logic fin;       // build the result
    } t_cmd;

    typedef struct packed {
        logic has_result;
        logic is_read;
        logic div_done;
    } t_sts;

endpackage

// ===== rtl/sst_ctrl.sv =====
// Sequencer for the stopwatch slot table.
// Depends on sst_pkg for the command and status structs.
module sst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  sst_pkg::t_sts  i_sts,
    output sst_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_SUB, S_DIV, S_FIN, S_OUT} t_state;
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (!i_sts.has_result) n_state = S_IDLE;
                else if (i_sts.is_read) n_state = S_MUL;
                else n_state = S_FIN;
            end
            S_MUL: begin
                o_cmd.mul_go = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_out_valid && !i_out_stall && !o_cmd.fin) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// ===== rtl/sst_dpath.sv =====
// Datapath for the stopwatch slot table: countdown sources, slot store,
// multiply and byte-wise reciprocal division by one million. Depends on sst_pkg.
module sst_dpath #(
    parameter int NUM_SLOTS   = sst_pkg::NUM_SLOTS_DEF,
    parameter int NUM_SOURCES = sst_pkg::NUM_SOURCES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sst_pkg::t_in_beat    i_in,
    input  logic [25:0]          i_period,
    input  sst_pkg::t_cmd        i_cmd,
    output sst_pkg::t_sts        o_sts,
    output sst_pkg::t_out_beat   o_out
);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PW = 58;   // 32 + 26 product bits
    localparam int NW = 64;   // dividend and quotient, eight byte digits
    localparam logic [4:0]  DIV_STEPS = 5'd16;
    localparam logic [36:0] RECIP     = 37'd268;  // floor(2^28 / 1e6)

    logic [25:0] w_eff;
    assign w_eff = (i_period == '0) ? sst_pkg::USEC_PER_SEC : i_period;

    logic [31:0] r_wrap [NUM_SOURCES];
    logic [25:0] r_rem  [NUM_SOURCES];
    logic [NUM_SLOTS-1:0] r_used;
    logic [1:0]  r_src  [NUM_SLOTS];
    logic [31:0] r_swrap [NUM_SLOTS];
    logic [25:0] r_srem  [NUM_SLOTS];

    sst_pkg::t_in_beat r_beat;
    logic [1:0]  r_status;
    logic [4:0]  r_slot;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] w_free;
    logic          w_any_free;
    logic [25:0] r_mem_rem;
    logic [31:0] r_dw;
    logic [25:0] r_cur;
    logic [NW-1:0] r_total;
    logic        r_neg;
    logic [NW-1:0] r_quo;
    logic [19:0] r_part;
    logic [27:0] r_t;
    logic [7:0]  r_qe;
    logic [4:0]  r_cnt;
    logic [PW-1:0] w_prod;
    logic [PW-1:0] w_sum;
    logic [27:0] w_t;
    logic [36:0] w_qprod;
    logic [28:0] w_rem0;
    logic [28:0] w_rem1;

    always_comb begin
        w_free     = '0;
        w_any_free = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free     = SW'(i);
                w_any_free = 1'b1;
            end
        end
    end

    logic w_id_ok;
    assign w_id_ok = (r_beat.slot_id != '0) && ({1'b0, r_beat.slot_id} <= 6'(NUM_SLOTS))
                     && r_used[r_idx];

    assign o_sts.has_result = (r_beat.kind != sst_pkg::KIND_TICK);
    assign o_sts.is_read    = (r_beat.kind == sst_pkg::KIND_READ) && w_id_ok;
    assign o_sts.div_done   = (r_cnt == 5'd0);

    assign w_prod  = PW'(r_dw) * PW'(w_eff);
    assign w_sum   = w_prod + PW'(r_mem_rem);
    assign w_t     = {r_part, r_total[NW-1:NW-8]};
    assign w_qprod = 37'(w_t) * RECIP;
    assign w_rem0  = 29'(r_t) - 29'(r_qe) * 29'(sst_pkg::USEC_PER_SEC);
    assign w_rem1  = 29'(r_t) - (29'(r_qe) + 29'd1) * 29'(sst_pkg::USEC_PER_SEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            for (int s = 0; s < NUM_SOURCES; s++) begin
                r_wrap[s] <= '0;
                r_rem[s]  <= sst_pkg::USEC_PER_SEC;
            end
            for (int i = 0; i < NUM_SLOTS; i++) r_src[i] <= '0;
        end else begin
            if (i_cmd.load) begin
                r_beat <= i_in;
                r_idx  <= SW'(i_in.slot_id - 5'd1);
            end
            if (i_cmd.exec) begin
                r_mem_rem  <= r_srem[r_idx];
                case (r_beat.kind)
                    sst_pkg::KIND_TICK: begin
                        r_status <= sst_pkg::ST_OK;
                        r_slot   <= '0;
                        for (int s = 0; s < NUM_SOURCES; s++) begin
                            if (r_beat.tick_mask[s]) begin
                                if (r_rem[s] <= 26'd1) begin
                                    r_rem[s]  <= w_eff;
                                    r_wrap[s] <= r_wrap[s] + 32'd1;
                                end else begin
                                    r_rem[s] <= r_rem[s] - 26'd1;
                                end
                            end
                        end
                    end
                    sst_pkg::KIND_START: begin
                        if (!w_any_free) begin
                            r_status <= sst_pkg::ST_NO_FREE;
                            r_slot   <= '0;
                        end else if (r_beat.source >= 2'(NUM_SOURCES)
                                     || r_beat.source == 2'd3) begin
                            r_status <= sst_pkg::ST_BAD_SRC;
                            r_slot   <= '0;
                        end else begin
                            r_status        <= sst_pkg::ST_OK;
                            r_used[w_free]  <= 1'b1;
                            r_src[w_free]   <= r_beat.source;
                            r_swrap[w_free] <= r_wrap[r_beat.source];
                            r_srem[w_free]  <= r_rem[r_beat.source];
                            r_slot          <= 5'(w_free) + 5'd1;
                        end
                    end
                    default: begin
                        if (!w_id_ok) begin
                            r_status <= sst_pkg::ST_NOT_FND;
                            r_slot   <= '0;
                        end else begin
                            r_status <= sst_pkg::ST_OK;
                            r_slot   <= r_beat.slot_id;
                            if (r_beat.kind == sst_pkg::KIND_STOP) begin
                                r_used[r_idx] <= 1'b0;
                                r_src[r_idx]  <= '0;
                            end
                        end
                    end
                endcase
                if (o_sts.is_read) begin
                    r_dw  <= r_wrap[(r_src[r_idx] >= 2'(NUM_SOURCES)) ? 2'd0 : r_src[r_idx]]
                             - r_swrap[r_idx];
                    r_cur <= r_rem[(r_src[r_idx] >= 2'(NUM_SOURCES)) ? 2'd0 : r_src[r_idx]];
                end else begin
                    r_dw  <= '0;
                    r_cur <= '0;
                end
            end
            if (i_cmd.mul_go) begin
                r_total <= NW'(w_sum - PW'(r_cur));
                r_neg   <= w_sum < PW'(r_cur);
                r_part  <= '0;
                r_quo   <= '0;
                r_cnt   <= DIV_STEPS;
            end
            if (i_cmd.div_step && r_cnt != 5'd0) begin
                r_cnt <= r_cnt - 5'd1;
                if (!r_cnt[0]) begin
                    r_t     <= w_t;
                    r_qe    <= w_qprod[35:28];
                    r_total <= {r_total[NW-9:0], 8'd0};
                end else if (!w_rem1[28]) begin
                    r_part <= w_rem1[19:0];
                    r_quo  <= {r_quo[NW-9:0], r_qe + 8'd1};
                end else begin
                    r_part <= w_rem0[19:0];
                    r_quo  <= {r_quo[NW-9:0], r_qe};
                end
            end
            if (i_cmd.fin) begin
                o_out.status   <= r_status;
                o_out.slot_out <= r_slot;
                if (r_beat.kind == sst_pkg::KIND_READ && r_status == sst_pkg::ST_OK
                    && !r_neg) begin
                    if (|r_quo[NW-1:32]) begin
                        o_out.elapsed_sec  <= '1;
                        o_out.elapsed_usec <= 20'(sst_pkg::USEC_PER_SEC - 26'd1);
                    end else begin
                        o_out.elapsed_sec  <= r_quo[31:0];
                        o_out.elapsed_usec <= r_part;
                    end
                end else begin
                    o_out.elapsed_sec  <= '0;
                    o_out.elapsed_usec <= '0;
                end
            end
        end
    end
endmodule

// ===== rtl/stopwatch_slot_table.sv =====
// Channel   | dir | handshake             | payload
// in        | in  | i_in_valid/o_in_stall  | sst_pkg::t_in_beat
// out       | out | o_out_valid/i_out_stall| sst_pkg::t_out_beat
// cfg       | in  | APB psel/penable       | base_period_us at 0x0
// A tick runs exec only; a start, a stop or a failed read runs exec and the
// result step; a read of a busy slot runs exec, the multiply, the byte-wise
// divide by one million (estimate and fix-up per byte digit) and the result.
// One beat is in work at a time; the input stalls until it is done, and a
// result held by the output stall holds the next result in its last cycle.
// Synchronous active-low reset; sources reload, all slots free.
module stopwatch_slot_table #(
    parameter int NUM_SLOTS   = sst_pkg::NUM_SLOTS_DEF,
    parameter int NUM_SOURCES = sst_pkg::NUM_SOURCES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sst_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sst_pkg::t_out_beat o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [25:0] r_period;
    sst_pkg::t_cmd w_cmd;
    sst_pkg::t_sts w_sts;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {6'd0, r_period} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= sst_pkg::USEC_PER_SEC;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_period <= pwdata[25:0];
        end
    end

    sst_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    sst_dpath #(.NUM_SLOTS(NUM_SLOTS), .NUM_SOURCES(NUM_SOURCES)) u_dpath (
        .i_clk, .i_rst_n, .i_in(i_in_data), .i_period(r_period),
        .i_cmd(w_cmd), .o_sts(w_sts), .o_out(o_out_data)
    );

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> o_in_stall) else $error("input not stalled while busy");
    a_usec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.elapsed_usec < 20'd1000000) else $error("usec range");
    a_err_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != sst_pkg::ST_OK) |-> o_out_data.slot_out == 5'd0)
        else $error("slot on error");
endmodule

// ===== bench/sst_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the stopwatch slot table: tracks sources, slots and the period,
// predicts each result beat and compares it with the output channel.
// Depends on sst_pkg for the beat types and codes.
module sst_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  sst_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  sst_pkg::t_out_beat i_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 o_errors,
    output int                 o_pending
);
    localparam int SLOTS = sst_pkg::NUM_SLOTS_DEF;
    localparam int SRCS  = sst_pkg::NUM_SOURCES_DEF;

    logic [25:0] period_reg;
    logic [31:0] src_wraps  [SRCS];
    logic [25:0] src_remain [SRCS];
    logic        slot_busy  [SLOTS];
    logic [1:0]  slot_src   [SLOTS];
    logic [31:0] slot_wraps [SLOTS];
    logic [25:0] slot_remain[SLOTS];

    sst_pkg::t_out_beat result_q[$];

    function automatic logic [25:0] eff_period();
        return (period_reg == 26'd0) ? sst_pkg::USEC_PER_SEC : period_reg;
    endfunction

    task automatic clear_state();
        period_reg = sst_pkg::USEC_PER_SEC;
        for (int s = 0; s < SRCS; s++) begin
            src_wraps[s]  = '0;
            src_remain[s] = sst_pkg::USEC_PER_SEC;
        end
        for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i]   = 1'b0;
            slot_src[i]    = '0;
            slot_wraps[i]  = '0;
            slot_remain[i] = '0;
        end
    endtask

    task automatic make_result(input logic [1:0] st, input logic [4:0] sl,
                               input logic [31:0] sec, input logic [19:0] us);
        sst_pkg::t_out_beat r;
        r.status = st;
        r.slot_out = sl;
        r.elapsed_sec = sec;
        r.elapsed_usec = us;
        result_q.push_back(r);
    endtask

    task automatic predict_beat(input sst_pkg::t_in_beat b);
        int          free_idx;
        int          idx;
        int          s;
        logic [31:0] wdiff;
        logic [63:0] total;
        logic [63:0] cur;
        logic [63:0] secs;
        free_idx = -1;
        case (b.kind)
            sst_pkg::KIND_TICK: begin
                for (s = 0; s < SRCS; s++) begin
                    if (b.tick_mask[s]) begin
                        if (src_remain[s] <= 26'd1) begin
                            src_remain[s] = eff_period();
                            src_wraps[s] = src_wraps[s] + 32'd1;
                        end else begin
                            src_remain[s] = src_remain[s] - 26'd1;
                        end
                    end
                end
            end
            sst_pkg::KIND_START: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!slot_busy[i]) free_idx = i;
                if (free_idx < 0) begin
                    make_result(sst_pkg::ST_NO_FREE, '0, '0, '0);
                end else if (b.source >= SRCS) begin
                    make_result(sst_pkg::ST_BAD_SRC, '0, '0, '0);
                end else begin
                    slot_busy[free_idx]   = 1'b1;
                    slot_src[free_idx]    = b.source;
                    slot_wraps[free_idx]  = src_wraps[b.source];
                    slot_remain[free_idx] = src_remain[b.source];
                    make_result(sst_pkg::ST_OK, 5'(free_idx + 1), '0, '0);
                end
            end
            default: begin
                if (b.slot_id == 5'd0 || b.slot_id > SLOTS || !slot_busy[b.slot_id - 1]) begin
                    make_result(sst_pkg::ST_NOT_FND, '0, '0, '0);
                end else if (b.kind == sst_pkg::KIND_STOP) begin
                    idx = b.slot_id - 1;
                    slot_busy[idx] = 1'b0;
                    slot_src[idx]  = '0;
                    make_result(sst_pkg::ST_OK, b.slot_id, '0, '0);
                end else begin
                    idx = b.slot_id - 1;
                    s = slot_src[idx];
                    wdiff = src_wraps[s] - slot_wraps[idx];
                    total = 64'(wdiff) * 64'(eff_period()) + 64'(slot_remain[idx]);
                    cur = 64'(src_remain[s]);
                    if (total < cur) begin
                        make_result(sst_pkg::ST_OK, b.slot_id, '0, '0);
                    end else begin
                        total = total - cur;
                        secs = total / 64'd1000000;
                        if (secs > 64'hFFFF_FFFF)
                            make_result(sst_pkg::ST_OK, b.slot_id, 32'hFFFF_FFFF, 20'd999999);
                        else
                            make_result(sst_pkg::ST_OK, b.slot_id, secs[31:0],
                                        20'(total % 64'd1000000));
                    end
                end
            end
        endcase
    endtask

    assign o_pending = result_q.size();

    always @(posedge i_clk) begin
        sst_pkg::t_out_beat e;
        if (!i_rst_n) begin
            o_errors = 0;
            clear_state();
            result_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 2'd0)
                period_reg = pwdata[25:0];
            if (i_in_valid && !i_in_stall)
                predict_beat(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= 10)
                        $display("%0t: unexpected result beat %p", $realtime, i_out_data);
                end else begin
                    e = result_q.pop_front();
                    if (e.status !== i_out_data.status || e.slot_out !== i_out_data.slot_out ||
                        e.elapsed_sec !== i_out_data.elapsed_sec ||
                        e.elapsed_usec !== i_out_data.elapsed_usec) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= 10)
                            $display({"%0t: mismatch exp st=%0d slot=%0d sec=%0d us=%0d",
                                      " got st=%0d slot=%0d sec=%0d us=%0d"},
                                $realtime, e.status, e.slot_out, e.elapsed_sec, e.elapsed_usec,
                                i_out_data.status, i_out_data.slot_out,
                                i_out_data.elapsed_sec, i_out_data.elapsed_usec);
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_stopwatch_slot_table.sv =====
`timescale 1ns / 100ps
// Top of the stopwatch slot table bench: clock, reset, stimulus and verdict.
// Depends on sst_pkg, the stopwatch_slot_table block and sst_checker.
module tb_stopwatch_slot_table;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    sst_pkg::t_in_beat  in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    sst_pkg::t_out_beat out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    bit          send_gaps = 1'b0;
    bit          recv_stalls = 1'b0;
    int unsigned cycles = 0;

    always #5 i_clk = ~i_clk;

    stopwatch_slot_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sst_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        out_stall <= recv_stalls && ($urandom_range(0, 99) < 67);
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_beat(input sst_pkg::t_in_beat b);
        if (send_gaps) begin
            while ($urandom_range(0, 99) < 67) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic beat_of(input logic [1:0] k, input logic [2:0] m, input logic [1:0] s,
                           input logic [4:0] id);
        sst_pkg::t_in_beat b;
        b.kind = k;
        b.tick_mask = m;
        b.source = s;
        b.slot_id = id;
        send_beat(b);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic sst_pkg::t_in_beat random_beat();
        sst_pkg::t_in_beat b;
        int r;
        b.tick_mask = 3'($urandom_range(0, 7));
        b.source = 2'($urandom_range(0, 3));
        b.slot_id = 5'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        if (r < 40) b.kind = sst_pkg::KIND_TICK;
        else if (r < 60) b.kind = sst_pkg::KIND_START;
        else if (r < 78) b.kind = sst_pkg::KIND_STOP;
        else b.kind = sst_pkg::KIND_READ;
        if ($urandom_range(0, 9) != 0) b.source = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 9) != 0) b.slot_id = 5'($urandom_range(1, 16));
        return b;
    endfunction

    initial begin
        logic [31:0] periods[8];
        periods = '{32'd4, 32'd1, 32'd0, 32'd67108863, 32'd9, 32'd2, 32'd0, 32'd7};
        periods[6] = $urandom_range(2, 40);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_period(32'd3);
        beat_of(sst_pkg::KIND_START, 3'd0, 2'd0, 5'd0);
        beat_of(sst_pkg::KIND_START, 3'd0, 2'd1, 5'd0);
        beat_of(sst_pkg::KIND_START, 3'd0, 2'd2, 5'd0);
        beat_of(sst_pkg::KIND_START, 3'd0, 2'd3, 5'd0);
        repeat (4) beat_of(sst_pkg::KIND_TICK, 3'd7, 2'd0, 5'd0);
        beat_of(sst_pkg::KIND_TICK, 3'd1, 2'd0, 5'd0);
        beat_of(sst_pkg::KIND_READ, 3'd0, 2'd0, 5'd1);
        beat_of(sst_pkg::KIND_READ, 3'd0, 2'd0, 5'd2);
        beat_of(sst_pkg::KIND_READ, 3'd0, 2'd0, 5'd3);
        beat_of(sst_pkg::KIND_STOP, 3'd0, 2'd0, 5'd0);
        beat_of(sst_pkg::KIND_READ, 3'd0, 2'd0, 5'd17);
        beat_of(sst_pkg::KIND_READ, 3'd0, 2'd0, 5'd31);
        beat_of(sst_pkg::KIND_STOP, 3'd0, 2'd0, 5'd2);
        beat_of(sst_pkg::KIND_READ, 3'd0, 2'd0, 5'd2);
        for (int i = 0; i < 15; i++) beat_of(sst_pkg::KIND_START, 3'd0, 2'(i % 3), 5'd0);
        settle();
        write_period(32'd67108863);
        beat_of(sst_pkg::KIND_READ, 3'd0, 2'd0, 5'd1);
        beat_of(sst_pkg::KIND_READ, 3'd0, 2'd0, 5'd16);

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            write_period(periods[ph]);
            send_gaps = (ph % 4 == 1) || (ph % 4 == 3);
            recv_stalls = (ph % 4 == 2) || (ph % 4 == 3);
            for (int n = 0; n < 175; n++) send_beat(random_beat());
        end
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        settle();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
